>>> sv/egarch_log_likelihood_filter_top_macros.svh
// Assertion helpers for the log-likelihood filter
`ifndef EGARCH_LOG_LIKELIHOOD_FILTER_TOP_MACROS_SVH
`define EGARCH_LOG_LIKELIHOOD_FILTER_TOP_MACROS_SVH
// implication checked every clock outside reset
`define ELF_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("violation");
// next-cycle implication
`define ELF_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("violation");
`endif

>>> sv/elf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package elf_pkg;
  localparam int unsigned LV_W  = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned RET_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd4;

  localparam longint LOG2E_Q30   = 64'sd1549082005;
  localparam longint LN2_Q30     = 64'sd744261118;
  localparam longint LN2PI_Q30   = 64'sd1973405474;
  localparam longint ABSMEAN_Q30 = 64'sd856722024;
  localparam longint ZLIM        = 64'sd2147483647;
  localparam longint SUM_MAX     = 64'sd140737488355327;
  localparam longint SUM_MIN     = -64'sd140737488355328;

  // datapath step commands
  typedef enum logic [3:0] {
    CMD_IDLE  = 4'd0,
    CMD_LOAD  = 4'd1,
    CMD_EXPY  = 4'd2,
    CMD_LUT   = 4'd3,
    CMD_INTRP = 4'd4,
    CMD_ZMUL  = 4'd5,
    CMD_ZSHF  = 4'd6,
    CMD_ACC   = 4'd7,
    CMD_UPD   = 4'd8
  } elf_cmd_t;

  typedef struct packed {
    elf_cmd_t cmd;
  } elf_ctl_t;

  typedef struct packed {
    logic busy;
  } elf_sts_t;
endpackage
`default_nettype wire

>>> sv/elf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface elf_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      return_sample;
  logic                    final_sample;
  modport source (output valid, return_sample, final_sample, input ready);
  modport sink (input valid, return_sample, final_sample, output ready);
endinterface

interface elf_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      log_variance;
  logic signed [47:0]      running_likelihood;
  logic                    invalid;
  logic                    series_end;
  modport source (output valid, log_variance, running_likelihood, invalid, series_end,
                  input ready);
  modport sink (input valid, log_variance, running_likelihood, invalid, series_end,
                output ready);
endinterface

interface elf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/elf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module elf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            res_free,
  output elf_pkg::elf_ctl_t    ctl
);
  import elf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXPY = 9'b000000010,
    S_LUT  = 9'b000000100,
    S_INT  = 9'b000001000,
    S_ZMUL = 9'b000010000,
    S_ZSHF = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_WAIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // sequence one sample through the datapath steps
  always_comb begin
    state_nxt = state_r;
    ctl.cmd = CMD_IDLE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin ctl.cmd = CMD_LOAD; state_nxt = S_EXPY; end
      S_EXPY: begin ctl.cmd = CMD_EXPY; state_nxt = S_LUT; end
      S_LUT:  begin ctl.cmd = CMD_LUT; state_nxt = S_INT; end
      S_INT:  begin ctl.cmd = CMD_INTRP; state_nxt = S_ZMUL; end
      S_ZMUL: begin ctl.cmd = CMD_ZMUL; state_nxt = S_ZSHF; end
      S_ZSHF: begin ctl.cmd = CMD_ZSHF; state_nxt = S_ACC; end
      S_ACC:  begin ctl.cmd = CMD_ACC; state_nxt = S_WAIT; end
      S_WAIT: if (res_free) begin ctl.cmd = CMD_UPD; state_nxt = S_IDLE; end
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

>>> sv/elf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module elf_dp #(
  parameter int RETURN_FRAC_BITS = 30,
  parameter int LOGVAR_FRAC_BITS = 23,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  elf_pkg::elf_ctl_t        ctl,
  input  wire logic signed [31:0]  in_r,
  input  wire logic                in_final,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [31:0]         cfg_data,
  output logic                     res_load,
  output logic signed [31:0]       res_lv,
  output logic signed [47:0]       res_sum,
  output logic                     res_inv,
  output logic                     res_end
);
  import elf_pkg::*;

  localparam int TW = $clog2(EXP_TABLE_DEPTH);
  localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam longint LN2PI_L = (LOGVAR_FRAC_BITS >= 30) ?
    LN2PI_Q30 * (64'sd1 << (LOGVAR_FRAC_BITS - 30)) :
    ((LN2PI_Q30 + (64'sd1 << (29 - LOGVAR_FRAC_BITS))) >>> (30 - LOGVAR_FRAC_BITS));
  localparam longint ABSM_L = (LOGVAR_FRAC_BITS >= 30) ?
    ABSMEAN_Q30 * (64'sd1 << (LOGVAR_FRAC_BITS - 30)) :
    ((ABSMEAN_Q30 + (64'sd1 << (29 - LOGVAR_FRAC_BITS))) >>> (30 - LOGVAR_FRAC_BITS));

  // 2^(k/depth) in Q30, truncated series
  function automatic logic [31:0] rom_val(input int k);
    logic [63:0] x, term, sum;
    x = (64'(k) * 64'(LN2_Q30)) / 64'(EXP_TABLE_DEPTH);
    term = 64'd1 << 30;
    sum = 64'd1 << 30;
    for (int i = 1; i <= 20; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      sum = sum + term;
    end
    return sum[31:0];
  endfunction

  logic [31:0] rom [0:EXP_TABLE_DEPTH];
  always_comb begin
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) rom[k] = rom_val(k);
  end

  logic signed [26:0] off_r;
  logic        [23:0] mag_r;
  logic signed [24:0] sgn_r;
  logic        [22:0] pers_r;
  logic signed [31:0] start_r;
  logic signed [31:0] lh_r;
  logic signed [47:0] sum_r;
  logic               ovf_r, at_start_r;
  logic signed [31:0] r_r;
  logic               fin_r;
  logic signed [63:0] y_r;
  logic [31:0]        lo_r, hi_r, g_r, m_r;
  logic [63:0]        pm_r;
  logic [31:0]        zm_r;
  logic signed [63:0] acc_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0; mag_r <= '0; sgn_r <= '0; pers_r <= '0; start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET: off_r  <= cfg_data[26:0];
        REG_MAG:    mag_r  <= cfg_data[23:0];
        REG_SIGN:   sgn_r  <= cfg_data[24:0];
        REG_PERS:   pers_r <= cfg_data[22:0];
        REG_START:  start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-step combinational values
  logic signed [63:0] y_c;
  logic [31:0]        f_c;
  logic [31+TW:0]     fd_c;
  logic [AW-1:0]      idx_c;
  logic signed [31:0] n_c;
  logic signed [31:0] s_c;
  logic [63:0]        zm_c;
  logic               zovf_c;
  logic [63:0]        zsq_c;
  logic signed [49:0] sumn_c;
  logic signed [31:0] a_r_abs;
  logic signed [33:0] zc_c;
  logic signed [63:0] acc_c, nl_c;
  logic signed [32:0] zs_c;
  logic [32:0]        diff_c;
  logic signed [31:0] nl_sat_c;
  logic               nl_ovf_c;
  logic               inv_c;

  always_comb begin
    y_c  = (-(64'(lh_r) * LOG2E_Q30)) >>> (LOGVAR_FRAC_BITS - 1);
    n_c  = 32'(y_r >>> 32);
    f_c  = y_r[31:0];
    fd_c = {{TW{1'b0}}, f_c} * (TW+32)'(EXP_TABLE_DEPTH);
    idx_c = AW'(fd_c[31+TW:32]);
    diff_c = (hi_r > lo_r) ? {1'b0, hi_r - lo_r} : 33'd0;
    s_c = 32'(RETURN_FRAC_BITS + 30 - LOGVAR_FRAC_BITS) - n_c;
    zm_c = '0;
    zovf_c = 1'b0;
    if (s_c > 0) begin
      if (s_c < 63) zm_c = (pm_r + (64'd1 << (s_c - 1))) >> s_c;
    end else if (pm_r != 0) begin
      if (-s_c >= 32 || pm_r > (64'(ZLIM) >> (-s_c))) zovf_c = 1'b1;
      else zm_c = pm_r << (-s_c);
    end
    zsq_c = (64'(zm_r) * 64'(zm_r) + (64'd1 << (LOGVAR_FRAC_BITS - 1))) >> LOGVAR_FRAC_BITS;
    sumn_c = 50'(sum_r) + 50'((-(64'(LN2PI_L) + 64'(lh_r) + $signed(zsq_c))) >>> 1);
    zs_c = r_r[31] ? -$signed({1'b0, zm_r}) : $signed({1'b0, zm_r});
    zc_c = $signed({2'b0, zm_r}) - 34'(ABSM_L);
    acc_c = $signed({40'd0, mag_r}) * 64'(zc_c) + 64'(sgn_r) * 64'(zs_c)
          + $signed({41'd0, pers_r}) * 64'(lh_r);
    nl_c = ((acc_r + (64'sd1 <<< (LOGVAR_FRAC_BITS - 1))) >>> LOGVAR_FRAC_BITS) + 64'(off_r);
    // saturate the new log variance to 32 bits
    nl_sat_c = nl_c[31:0];
    nl_ovf_c = 1'b0;
    if (nl_c > 64'sd2147483647) begin
      nl_sat_c = 32'sh7fffffff; nl_ovf_c = 1'b1;
    end else if (nl_c < -64'sd2147483648) begin
      nl_sat_c = 32'sh80000000; nl_ovf_c = 1'b1;
    end
    inv_c = ovf_r || (!fin_r && nl_ovf_c);
    a_r_abs = r_r;
  end

  // step the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lh_r <= '0; sum_r <= '0; ovf_r <= 1'b0; at_start_r <= 1'b1; res_load <= 1'b0;
    end else begin
      res_load <= (ctl.cmd == CMD_UPD);
      unique case (ctl.cmd)
        CMD_LOAD: begin
          r_r <= in_r; fin_r <= in_final;
          if (at_start_r) begin
            lh_r <= start_r; sum_r <= '0; ovf_r <= 1'b0; at_start_r <= 1'b0;
          end
        end
        CMD_EXPY: y_r <= y_c;
        CMD_LUT: begin
          lo_r <= rom[idx_c]; hi_r <= rom[idx_c + AW'(1)]; g_r <= fd_c[31:0];
        end
        CMD_INTRP: m_r <= lo_r + 32'((64'(diff_c) * 64'(g_r)) >> 32);
        CMD_ZMUL: pm_r <= 64'(a_r_abs[31] ? -64'(a_r_abs) : 64'(a_r_abs)) * 64'(m_r);
        CMD_ZSHF: begin
          if (zovf_c || zm_c > 64'(ZLIM)) begin
            zm_r <= 32'(ZLIM); ovf_r <= 1'b1;
          end else zm_r <= zm_c[31:0];
        end
        CMD_ACC: begin
          acc_r <= acc_c;
          if (sumn_c > 50'(SUM_MAX)) begin sum_r <= 48'(SUM_MAX); ovf_r <= 1'b1; end
          else if (sumn_c < 50'(SUM_MIN)) begin sum_r <= 48'(SUM_MIN); ovf_r <= 1'b1; end
          else sum_r <= sumn_c[47:0];
        end
        CMD_UPD: begin
          res_lv <= lh_r; res_end <= fin_r;
          res_inv <= inv_c;
          res_sum <= inv_c ? 48'(SUM_MIN) : sum_r;
          ovf_r <= inv_c;
          if (!fin_r) lh_r <= nl_sat_c;
          else at_start_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/egarch_log_likelihood_filter_top.sv
`timescale 1ns / 1ps
// EGARCH(1,1) Gaussian log-likelihood filter.
// in_ channel: one demeaned return (Q1.30) per transfer plus a final flag.
// out_ channel: log variance used (Q8.23), running log-likelihood (Q24.23),
//   sticky invalid flag (likelihood is minus infinity) and series end.
// cfg_ channel: register index 0..4 and data; write only while idle.
// Each sample runs through an eight-step sequence of one shared datapath:
//   load, exponent, table read, interpolation, multiply, shift, accumulate, update.
// A new sample is taken only after the previous one's update step, as the
//   log-variance recursion loop needs the new log variance it writes.
// One output register holds the result; the next sample is taken while it
//   waits, but its update step stalls until the output is free.
// Reset clears the configuration registers, log variance, sum and flags; the
//   next sample starts a series from start_log_variance.
`default_nettype none
module egarch_log_likelihood_filter_top #(
  parameter int RETURN_FRAC_BITS = 30,
  parameter int LOGVAR_FRAC_BITS = 23,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  elf_in_if.sink   in_ch,
  elf_out_if.source out_ch,
  elf_cfg_if.sink  cfg_ch
);
  import elf_pkg::*;

  elf_ctl_t ctl;
  logic res_load, res_inv, res_end, out_valid_r, res_free;
  logic signed [31:0] res_lv;
  logic signed [47:0] res_sum;

  assign cfg_ch.ready = 1'b1;
  assign res_free = !out_valid_r || out_ch.ready;

  elf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_free(res_free), .ctl(ctl)
  );

  elf_dp #(
    .RETURN_FRAC_BITS(RETURN_FRAC_BITS), .LOGVAR_FRAC_BITS(LOGVAR_FRAC_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_r(in_ch.return_sample),
    .in_final(in_ch.final_sample), .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index),
    .cfg_data(cfg_ch.data), .res_load(res_load), .res_lv(res_lv), .res_sum(res_sum),
    .res_inv(res_inv), .res_end(res_end)
  );

  // hold result until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.log_variance = res_lv;
  assign out_ch.running_likelihood = res_sum;
  assign out_ch.invalid = res_inv;
  assign out_ch.series_end = res_end;
endmodule
`default_nettype wire

>>> sv/elf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "egarch_log_likelihood_filter_top_macros.svh"
module elf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_invalid,
  input wire logic [47:0] out_sum
);
  `ELF_ASSERT_IMP(a_inv_sum, clk, rst_n, out_valid && out_invalid, out_sum == 48'h800000000000)
  `ELF_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `ELF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind egarch_log_likelihood_filter_top elf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_invalid(out_ch.invalid),
  .out_sum(out_ch.running_likelihood)
);
`default_nettype wire
